// ===== sv/char_lcd_nibble_write_sequencer_top_assert.svh =====
// Assertion macros used by the character LCD back sequencer module.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_TOP_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_TOP_ASSERT_SVH

// Checks that a condition implies another one in the same cycle.
`define LCDNW_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that a condition implies another one in the next cycle.
`define LCDNW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/lcdnw_pkg.sv =====
package lcdnw_pkg;

   // Display geometry and timer sizing.
   localparam int COLUMNS    = 16;
   localparam int TIMER_BITS = 20;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

   // Configuration port sizing.
   localparam int CFG_BITS   = 20;
   localparam int PULSE_BITS = 16;
   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PULSE_TICKS     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SETTLE_TICKS    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INIT_WAIT_TICKS = 2'd2;

   // Register reset values.
   localparam logic [PULSE_BITS-1:0] PULSE_RESET     = 16'd5;
   localparam logic [CFG_BITS-1:0]   SETTLE_RESET    = 20'd100;
   localparam logic [CFG_BITS-1:0]   INIT_WAIT_RESET = 20'd10000;

   // Stream widths.
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 16;

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Init sequence.
   localparam int INIT_LEN = 5;
   localparam int IDX_BITS = $clog2(INIT_LEN + 1);

   // Fixed LCD command bytes.
   localparam logic [7:0] LCD_CLEAR    = 8'h01;
   localparam logic [7:0] LCD_ROW0_DDR = 8'h80;
   localparam logic [7:0] LCD_ROW1_DDR = 8'hC0;

   // Request codes on the action field.
   typedef enum logic [2:0] {
      ACT_TICK  = 3'd0,
      ACT_DATA  = 3'd1,
      ACT_CMD   = 3'd2,
      ACT_GOTO  = 3'd3,
      ACT_INIT  = 3'd4,
      ACT_CLEAR = 3'd5
   } act_type;

   // Classified request kinds handed from front to back.
   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_WRITE,
      CMD_INIT,
      CMD_REFUSE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data_byte;
      logic         sel;
   } cmd_type;

   // Sequencer phases.
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HI,
      PH_GAP,
      PH_LO,
      PH_SETTLE,
      PH_INITWAIT
   } phase_type;

   // Byte sent at a given step of the init sequence.
   function automatic logic [7:0] init_byte(input logic [IDX_BITS-1:0] k);
      logic [7:0] b;
      case (k)
         3'd0:    b = 8'h32;
         3'd1:    b = 8'h28;
         3'd2:    b = 8'h0C;
         3'd3:    b = 8'h06;
         3'd4:    b = 8'h01;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Tick count loaded into the timer: zero counts as one, large values saturate.
   function automatic logic [TIMER_BITS-1:0] load_count(input logic [CFG_BITS-1:0] v);
      logic [TIMER_BITS-1:0] c;
      if (v == '0) begin
         c = TIMER_BITS'(1);
      end else if (v > CFG_BITS'(TIMER_MAX)) begin
         c = TIMER_MAX;
      end else begin
         c = TIMER_BITS'(v);
      end
      return c;
   endfunction

endpackage

// ===== sv/lcdnw_front.sv =====
module lcdnw_front (
   input  logic [lcdnw_pkg::REQ_DATA_BITS-1:0] req_data,
   output lcdnw_pkg::cmd_type                  cmd
);

   logic [2:0] action;
   logic [7:0] value;
   logic [7:0] column;
   logic [7:0] row;
   logic [7:0] goto_base;

   assign action = req_data[2:0];
   assign value  = req_data[10:3];
   assign column = req_data[18:11];
   assign row    = req_data[26:19];

   assign goto_base = (row == 8'd0) ? lcdnw_pkg::LCD_ROW0_DDR : lcdnw_pkg::LCD_ROW1_DDR;

   // Turn each request into the byte it sends and the kind of work it needs.
   always_comb begin
      cmd.kind      = lcdnw_pkg::CMD_TICK;
      cmd.data_byte = value;
      cmd.sel       = 1'b0;
      case (lcdnw_pkg::act_type'(action))
         lcdnw_pkg::ACT_DATA: begin
            cmd.kind = lcdnw_pkg::CMD_WRITE;
            cmd.sel  = 1'b1;
         end
         lcdnw_pkg::ACT_CMD: begin
            cmd.kind = lcdnw_pkg::CMD_WRITE;
         end
         lcdnw_pkg::ACT_GOTO: begin
            if (column >= 8'(lcdnw_pkg::COLUMNS)) begin
               cmd.kind = lcdnw_pkg::CMD_REFUSE;
            end else begin
               cmd.kind = lcdnw_pkg::CMD_WRITE;
            end
            cmd.data_byte = goto_base + column;
         end
         lcdnw_pkg::ACT_INIT: begin
            cmd.kind      = lcdnw_pkg::CMD_INIT;
            cmd.data_byte = lcdnw_pkg::init_byte('0);
         end
         lcdnw_pkg::ACT_CLEAR: begin
            cmd.kind      = lcdnw_pkg::CMD_WRITE;
            cmd.data_byte = lcdnw_pkg::LCD_CLEAR;
         end
         default: begin
            cmd.kind = lcdnw_pkg::CMD_TICK;
         end
      endcase
   end

endmodule

// ===== sv/lcdnw_queue.sv =====
module lcdnw_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  lcdnw_pkg::cmd_type push_cmd,
   output logic               pop_valid,
   input  logic               pop_ready,
   output lcdnw_pkg::cmd_type pop_cmd
);

   lcdnw_pkg::cmd_type                entry_ff [lcdnw_pkg::QUEUE_DEPTH];
   logic [lcdnw_pkg::QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [lcdnw_pkg::QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [lcdnw_pkg::QCNT_BITS-1:0]   count_ff, count_in;
   logic                              push;
   logic                              pop;

   assign push_ready = (count_ff != lcdnw_pkg::QCNT_BITS'(lcdnw_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == lcdnw_pkg::QPTR_BITS'(lcdnw_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == lcdnw_pkg::QPTR_BITS'(lcdnw_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== sv/lcdnw_back.sv =====
`include "char_lcd_nibble_write_sequencer_top_assert.svh"

module lcdnw_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [lcdnw_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [lcdnw_pkg::CFG_BITS-1:0]        csr_wdata,
   input  logic                                  cmd_valid,
   output logic                                  cmd_ready,
   input  lcdnw_pkg::cmd_type                    cmd,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [lcdnw_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);

   // Configuration registers.
   logic [lcdnw_pkg::PULSE_BITS-1:0] pulse_ff;
   logic [lcdnw_pkg::CFG_BITS-1:0]   settle_ff;
   logic [lcdnw_pkg::CFG_BITS-1:0]   init_wait_ff;

   // Sequencer state.
   lcdnw_pkg::phase_type              phase_ff, phase_in, phase_a;
   logic [lcdnw_pkg::TIMER_BITS-1:0]  timer_ff, timer_in, timer_a, timer_dec;
   logic [7:0]                        byte_ff, byte_in, byte_a;
   logic                              sel_ff, sel_in, sel_a;
   logic [lcdnw_pkg::IDX_BITS-1:0]    idx_ff, idx_in, idx_a;
   logic [3:0]                        nib_ff, nib_in, nib_a;
   logic                              drop_a;
   logic [7:0]                        init_next;

   // Output register.
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [lcdnw_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                              pop;
   logic [lcdnw_pkg::CFG_BITS-1:0]    pulse_ext;

   assign cmd_ready  = !rsp_valid_ff || rsp_tready;
   assign pop        = cmd_valid && cmd_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign pulse_ext  = {{(lcdnw_pkg::CFG_BITS - lcdnw_pkg::PULSE_BITS){1'b0}}, pulse_ff};

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff     <= lcdnw_pkg::PULSE_RESET;
         settle_ff    <= lcdnw_pkg::SETTLE_RESET;
         init_wait_ff <= lcdnw_pkg::INIT_WAIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            lcdnw_pkg::CSR_PULSE_TICKS:     pulse_ff     <= csr_wdata[lcdnw_pkg::PULSE_BITS-1:0];
            lcdnw_pkg::CSR_SETTLE_TICKS:    settle_ff    <= csr_wdata;
            lcdnw_pkg::CSR_INIT_WAIT_TICKS: init_wait_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Apply this tick's request: a new byte starts only from idle.
   always_comb begin
      phase_a = phase_ff;
      timer_a = timer_ff;
      byte_a  = byte_ff;
      sel_a   = sel_ff;
      idx_a   = idx_ff;
      nib_a   = nib_ff;
      drop_a  = 1'b0;
      case (cmd.kind)
         lcdnw_pkg::CMD_WRITE, lcdnw_pkg::CMD_INIT: begin
            if (phase_ff != lcdnw_pkg::PH_IDLE) begin
               drop_a = 1'b1;
            end else begin
               phase_a = lcdnw_pkg::PH_HI;
               timer_a = lcdnw_pkg::load_count(pulse_ext);
               byte_a  = cmd.data_byte;
               sel_a   = cmd.sel;
               nib_a   = cmd.data_byte[7:4];
               if (cmd.kind == lcdnw_pkg::CMD_INIT) begin
                  idx_a = lcdnw_pkg::IDX_BITS'(1);
               end
            end
         end
         lcdnw_pkg::CMD_REFUSE: begin
            drop_a = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign timer_dec = (timer_a != '0) ? timer_a - 1'b1 : timer_a;

   // Byte of the init sequence that follows the current one.
   assign init_next = lcdnw_pkg::init_byte(idx_a);

   // Next state: count the tick down and step the phase when it runs out.
   always_comb begin
      phase_in = phase_a;
      timer_in = timer_a;
      byte_in  = byte_a;
      sel_in   = sel_a;
      idx_in   = idx_a;
      nib_in   = nib_a;
      if (phase_a != lcdnw_pkg::PH_IDLE) begin
         timer_in = timer_dec;
         if (timer_dec == '0) begin
            case (phase_a)
               lcdnw_pkg::PH_HI: begin
                  phase_in = lcdnw_pkg::PH_GAP;
                  timer_in = lcdnw_pkg::TIMER_BITS'(1);
                  nib_in   = byte_a[3:0];
               end
               lcdnw_pkg::PH_GAP: begin
                  phase_in = lcdnw_pkg::PH_LO;
                  timer_in = lcdnw_pkg::load_count(pulse_ext);
               end
               lcdnw_pkg::PH_LO: begin
                  phase_in = lcdnw_pkg::PH_SETTLE;
                  timer_in = lcdnw_pkg::load_count(settle_ff);
               end
               lcdnw_pkg::PH_SETTLE: begin
                  if (idx_a >= lcdnw_pkg::IDX_BITS'(1) &&
                      idx_a < lcdnw_pkg::IDX_BITS'(lcdnw_pkg::INIT_LEN)) begin
                     // Next byte of the init sequence.
                     idx_in   = idx_a + 1'b1;
                     byte_in  = init_next;
                     sel_in   = 1'b0;
                     nib_in   = init_next[7:4];
                     phase_in = lcdnw_pkg::PH_HI;
                     timer_in = lcdnw_pkg::load_count(pulse_ext);
                  end else if (idx_a == lcdnw_pkg::IDX_BITS'(lcdnw_pkg::INIT_LEN)) begin
                     idx_in   = '0;
                     phase_in = lcdnw_pkg::PH_INITWAIT;
                     timer_in = lcdnw_pkg::load_count(init_wait_ff);
                  end else begin
                     idx_in   = '0;
                     phase_in = lcdnw_pkg::PH_IDLE;
                     timer_in = '0;
                  end
               end
               default: begin
                  phase_in = lcdnw_pkg::PH_IDLE;
                  timer_in = '0;
               end
            endcase
         end
      end
   end

   // Outputs: pin levels after the request is taken, held in the output register.
   always_comb begin
      rsp_data_in      = '0;
      rsp_data_in[0]   = sel_a;
      rsp_data_in[1]   = 1'b0;
      rsp_data_in[2]   = (phase_a == lcdnw_pkg::PH_HI) || (phase_a == lcdnw_pkg::PH_LO);
      rsp_data_in[6:3] = nib_a;
      rsp_data_in[7]   = (phase_a != lcdnw_pkg::PH_IDLE);
      rsp_data_in[8]   = drop_a;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lcdnw_pkg::PH_IDLE;
         timer_ff     <= '0;
         byte_ff      <= '0;
         sel_ff       <= 1'b0;
         idx_ff       <= '0;
         nib_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff <= phase_in;
            timer_ff <= timer_in;
            byte_ff  <= byte_in;
            sel_ff   <= sel_in;
            idx_ff   <= idx_in;
            nib_ff   <= nib_in;
         end
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `LCDNW_ASSERT_SAME(a_idle_timer_zero, clock, reset,
      phase_ff == lcdnw_pkg::PH_IDLE, timer_ff == '0, "timer running while idle")
   `LCDNW_ASSERT_SAME(a_busy_timer_set, clock, reset,
      phase_ff != lcdnw_pkg::PH_IDLE, timer_ff != '0, "busy phase with empty timer")
   `LCDNW_ASSERT_SAME(a_init_in_byte, clock, reset,
      idx_ff != '0, phase_ff == lcdnw_pkg::PH_HI || phase_ff == lcdnw_pkg::PH_GAP ||
      phase_ff == lcdnw_pkg::PH_LO || phase_ff == lcdnw_pkg::PH_SETTLE,
      "init step pending outside a byte transfer")
   `LCDNW_ASSERT_SAME(a_enable_when_busy, clock, reset,
      rsp_valid_ff && rsp_data_ff[2], rsp_data_ff[7], "enable strobe while not busy")
   `LCDNW_ASSERT_NEXT(a_pop_gives_result, clock, reset,
      pop, rsp_valid_ff, "consumed item produced no result")

endmodule

// ===== sv/char_lcd_nibble_write_sequencer_top.sv =====
// Character LCD write sequencer for a 4-bit bus.
// Each item on the req_ stream is one time tick that may carry a request
// (write data, write command, go to position, init or clear). Every item
// gives exactly one item on the rsp_ stream: the pin levels for that tick
// (register select, read/write, enable, d7..d4) plus busy and dropped flags.
// A request that arrives while a byte is still being sent or settling, or
// during the init wait, is dropped and flagged, as is a go-to to a column past the display width.
// Throughput is one item per clock cycle while rsp_tready is high. A front
// decoder classifies each item into a two-entry queue; the back sequencer
// takes one item per cycle from the queue into its output register when that
// register is free, so each item is held in a queue entry and then in the
// output register before rsp_tvalid shows its result. The tick timer only
// changes pin levels, never the rate.
// When rsp_tready is low the output register holds its item, the queue
// fills with up to two more items and then req_tready drops.
// Synchronous reset returns the timing registers to their defaults
// (pulse 5, settle 100, init wait 10000), empties the queue and output
// register, and leaves the sequencer idle. The user must write registers
// through the csr_ port only while the block is idle; the block does not enforce this.
module char_lcd_nibble_write_sequencer_top (
   input  logic                                clock,
   input  logic                                reset,
   // Fields from bit 0: action[2:0], value[10:3], column[18:11], row[26:19].
   input  logic [lcdnw_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0: reg_select[0], read_write[1], enable[2],
   // bus_nibble[6:3], busy_res[7], dropped[8].
   output logic [lcdnw_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_wr_en,
   input  logic [lcdnw_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [lcdnw_pkg::CFG_BITS-1:0]      csr_wdata
);

   lcdnw_pkg::cmd_type front_cmd;
   lcdnw_pkg::cmd_type queue_cmd;
   logic               queue_valid;
   logic               queue_ready;

   // Request decoding.
   lcdnw_front u_front (
      .req_data (req_tdata),
      .cmd      (front_cmd)
   );

   // Decoupling queue.
   lcdnw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_cmd   (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_cmd    (queue_cmd)
   );

   // Pin sequencer.
   lcdnw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd_valid  (queue_valid),
      .cmd_ready  (queue_ready),
      .cmd        (queue_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== tb/lcd_pin_checker.sv =====
`timescale 1ns / 100ps

// Watches the request, result and register ports of the LCD write sequencer.
// It keeps its own copy of the sequencer state, works out the pin levels for
// every accepted item and compares them with the result stream in order.
module lcd_pin_checker
   import lcdnw_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CFG_BITS-1:0]      csr_wdata,
   output int                       mismatch_count,
   output int                       pins_pending,
   output logic                     seq_idle
);

   // Pin levels of one tick, laid out as the low bits of rsp_tdata.
   typedef struct packed {
      logic       dropped;
      logic       busy;
      logic [3:0] nibble;
      logic       strobe;
      logic       rd_wr;
      logic       sel;
   } lcd_pins_type;

   // Expected pin levels, oldest first.
   lcd_pins_type expected_pins[$];

   // Shadow of the sequencer state.
   phase_type             seq_phase;
   logic [TIMER_BITS-1:0] ticks_left;
   logic [7:0]            byte_held;
   logic                  sel_held;
   logic [IDX_BITS-1:0]   boot_step;
   logic [3:0]            nibble_held;

   // Shadow of the timing registers.
   logic [PULSE_BITS-1:0] pulse_cfg;
   logic [CFG_BITS-1:0]   settle_cfg;
   logic [CFG_BITS-1:0]   boot_wait_cfg;

   assign seq_idle = (seq_phase == PH_IDLE);

   // Power-up command bytes in the order they are sent.
   function automatic logic [7:0] boot_cmd(input logic [IDX_BITS-1:0] k);
      case (k)
         0:       return 8'h32;
         1:       return 8'h28;
         2:       return 8'h0C;
         3:       return 8'h06;
         default: return LCD_CLEAR;
      endcase
   endfunction

   // A zero count still lasts one tick; counts past the timer range saturate.
   function automatic logic [TIMER_BITS-1:0] timer_load(input logic [CFG_BITS-1:0] v);
      longint unsigned top;
      top = (longint'(1) << TIMER_BITS) - 1;
      if (v == '0) begin
         return TIMER_BITS'(1);
      end else if (longint'(v) > top) begin
         return '1;
      end
      return TIMER_BITS'(v);
   endfunction

   // Latch a byte and start its high-nibble strobe.
   task automatic start_byte(input logic [7:0] b, input logic s);
      byte_held   = b;
      sel_held    = s;
      nibble_held = b[7:4];
      seq_phase   = PH_HI;
      ticks_left  = timer_load(pulse_cfg);
   endtask

   // Move on once the current phase has run out of ticks.
   task automatic advance_phase;
      logic [IDX_BITS-1:0] k;
      case (seq_phase)
         PH_HI: begin
            seq_phase   = PH_GAP;
            ticks_left  = 1;
            nibble_held = byte_held[3:0];
         end
         PH_GAP: begin
            seq_phase  = PH_LO;
            ticks_left = timer_load(pulse_cfg);
         end
         PH_LO: begin
            seq_phase  = PH_SETTLE;
            ticks_left = timer_load(settle_cfg);
         end
         PH_SETTLE: begin
            if (boot_step >= 1 && boot_step < INIT_LEN) begin
               k = boot_step;
               boot_step = k + 1'b1;
               start_byte(boot_cmd(k), 1'b0);
            end else if (boot_step == INIT_LEN) begin
               boot_step  = '0;
               seq_phase  = PH_INITWAIT;
               ticks_left = timer_load(boot_wait_cfg);
            end else begin
               boot_step  = '0;
               seq_phase  = PH_IDLE;
               ticks_left = '0;
            end
         end
         default: begin
            seq_phase  = PH_IDLE;
            ticks_left = '0;
         end
      endcase
   endtask

   // Take one tick with its request and return the pins it produces.
   task automatic predict_tick(input logic [REQ_DATA_BITS-1:0] d, output lcd_pins_type p);
      logic [2:0] act;
      logic [7:0] val;
      logic [7:0] col;
      logic [7:0] row;
      logic       refused;
      act     = d[2:0];
      val     = d[10:3];
      col     = d[18:11];
      row     = d[26:19];
      refused = 1'b0;
      if (act >= ACT_DATA && act <= ACT_CLEAR) begin
         if (seq_phase != PH_IDLE) begin
            refused = 1'b1;
         end else begin
            case (act)
               ACT_DATA: start_byte(val, 1'b1);
               ACT_CMD:  start_byte(val, 1'b0);
               ACT_GOTO: begin
                  if (col >= COLUMNS) begin
                     refused = 1'b1;
                  end else begin
                     start_byte(((row == 8'd0) ? LCD_ROW0_DDR : LCD_ROW1_DDR) + col, 1'b0);
                  end
               end
               ACT_INIT: begin
                  boot_step = 1;
                  start_byte(boot_cmd(0), 1'b0);
               end
               ACT_CLEAR: start_byte(LCD_CLEAR, 1'b0);
               default: ;
            endcase
         end
      end
      p.sel     = sel_held;
      p.rd_wr   = 1'b0;
      p.strobe  = (seq_phase == PH_HI || seq_phase == PH_LO);
      p.nibble  = nibble_held;
      p.busy    = (seq_phase != PH_IDLE);
      p.dropped = refused;
      if (seq_phase != PH_IDLE) begin
         if (ticks_left != '0) begin
            ticks_left = ticks_left - 1'b1;
         end
         if (ticks_left == '0) begin
            advance_phase();
         end
      end
   endtask

   task automatic check_field(input string fname, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t lcd_pin_checker: %s expected %0h actual %0h", $time, fname, want, got);
         mismatch_count++;
      end
   endtask

   // Track register writes, predict on each accepted item, compare each result.
   always @(posedge clock) begin
      lcd_pins_type want;
      lcd_pins_type got;
      if (reset) begin
         expected_pins.delete();
         pulse_cfg     = PULSE_RESET;
         settle_cfg    = SETTLE_RESET;
         boot_wait_cfg = INIT_WAIT_RESET;
         seq_phase     = PH_IDLE;
         ticks_left    = '0;
         byte_held     = '0;
         sel_held      = 1'b0;
         boot_step     = '0;
         nibble_held   = '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PULSE_TICKS:     pulse_cfg     = csr_wdata[PULSE_BITS-1:0];
               CSR_SETTLE_TICKS:    settle_cfg    = csr_wdata;
               CSR_INIT_WAIT_TICKS: boot_wait_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_tick(req_tdata, want);
            expected_pins.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(lcd_pins_type)-1:0];
            if (expected_pins.size() == 0) begin
               $display("%0t lcd_pin_checker: result with none expected, actual %h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_pins.pop_front();
               check_field("reg_select", want.sel, got.sel);
               check_field("read_write", want.rd_wr, got.rd_wr);
               check_field("enable", want.strobe, got.strobe);
               check_field("bus_nibble", want.nibble, got.nibble);
               check_field("busy_res", want.busy, got.busy);
               check_field("dropped", want.dropped, got.dropped);
            end
         end
      end
      pins_pending = expected_pins.size();
   end

   initial begin
      mismatch_count = 0;
      pins_pending   = 0;
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import lcdnw_pkg::*;

   // Action codes outside the defined set; the block treats them as plain ticks.
   localparam logic [2:0] ACT_RSVD_A = 3'd6;
   localparam logic [2:0] ACT_RSVD_B = 3'd7;
   localparam logic [CFG_BITS-1:0] SETTLE_MAX = 20'hFFFFF;
   localparam int RUN_LIMIT = 2_000_000;

   logic                     clock = 1'b0;
   logic                     reset;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic                     csr_wr_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CFG_BITS-1:0]      csr_wdata;

   int   mismatch_count;
   int   pins_pending;
   logic seq_idle;
   int   send_idle_pct;
   int   rcv_stall_pct;
   int   cycle_count;

   char_lcd_nibble_write_sequencer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   lcd_pin_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tdata      (req_tdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pins_pending   (pins_pending),
      .seq_idle       (seq_idle)
   );

   // 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The result side stalls at random.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rcv_stall_pct);
   end

   // Offer one item and hold it until it is accepted; valid stays high after.
   task automatic send_item(input logic [2:0] act, input logic [7:0] val,
                            input logic [7:0] col, input logic [7:0] row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {5'd0, row, col, val, act};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering items and wait until every expected result has come back.
   task automatic wait_results;
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pins_pending != 0);
      @(posedge clock);
   endtask

   // Feed ticks until the sequencer has finished its byte and any waits.
   task automatic run_until_idle;
      wait_results();
      while (!seq_idle) begin
         repeat (8) send_item(ACT_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
         wait_results();
      end
   endtask

   // One request that is sent to an idle sequencer and run to completion.
   task automatic directed_request(input logic [2:0] act, input logic [7:0] val,
                                   input logic [7:0] col, input logic [7:0] row);
      send_item(act, val, col, row);
      run_until_idle();
   endtask

   // Write all three timing registers back to back; only called while idle.
   task automatic write_regs(input logic [CFG_BITS-1:0] pulse,
                             input logic [CFG_BITS-1:0] settle,
                             input logic [CFG_BITS-1:0] boot_wait);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_PULSE_TICKS;
      csr_wdata <= pulse;
      @(posedge clock);
      csr_index <= CSR_SETTLE_TICKS;
      csr_wdata <= settle;
      @(posedge clock);
      csr_index <= CSR_INIT_WAIT_TICKS;
      csr_wdata <= boot_wait;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly plain ticks and well-formed requests, with a share of noise.
   task automatic send_random_item;
      int         pick;
      logic [2:0] act;
      logic [7:0] val;
      logic [7:0] col;
      logic [7:0] row;
      pick = $urandom_range(99);
      val  = 8'($urandom);
      col  = 8'($urandom);
      row  = 8'($urandom);
      if (pick < 45) begin
         act = ACT_TICK;
      end else if (pick < 63) begin
         act = ACT_DATA;
      end else if (pick < 73) begin
         act = ACT_CMD;
      end else if (pick < 87) begin
         act = ACT_GOTO;
         if ($urandom_range(4) != 0) begin
            col = 8'($urandom_range(COLUMNS - 1));
         end
         if ($urandom_range(1) == 0) begin
            row = 8'd0;
         end
      end else if (pick < 91) begin
         act = ACT_INIT;
      end else if (pick < 96) begin
         act = ACT_CLEAR;
      end else begin
         act = 3'($urandom_range(ACT_RSVD_A, ACT_RSVD_B));
      end
      send_item(act, val, col, row);
   endtask

   task automatic random_items(input int count);
      repeat (count) send_random_item();
      run_until_idle();
   endtask

   // Stimulus.
   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      send_idle_pct = 7;
      rcv_stall_pct = 62;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // One byte with the reset timing, then the shortest timing.
      directed_request(ACT_DATA, 8'hA5, 8'h00, 8'h00);
      write_regs(1, 1, 1);

      // Byte extremes, both rows and the column edge, clear, init, spare codes.
      directed_request(ACT_DATA, 8'h00, 8'hFF, 8'hFF);
      directed_request(ACT_DATA, 8'hFF, 8'h00, 8'h00);
      directed_request(ACT_CMD, 8'h00, 8'h00, 8'h00);
      directed_request(ACT_CMD, 8'hFF, 8'hFF, 8'hFF);
      directed_request(ACT_GOTO, 8'h00, 8'd0, 8'd0);
      directed_request(ACT_GOTO, 8'hFF, 8'(COLUMNS - 1), 8'hFF);
      directed_request(ACT_GOTO, 8'h00, 8'(COLUMNS), 8'd1);
      directed_request(ACT_GOTO, 8'h00, 8'hFF, 8'd0);
      directed_request(ACT_CLEAR, 8'h00, 8'h00, 8'h00);
      directed_request(ACT_INIT, 8'h00, 8'h00, 8'h00);
      directed_request(ACT_RSVD_A, 8'hFF, 8'h00, 8'h00);
      directed_request(ACT_RSVD_B, 8'h00, 8'h00, 8'h00);

      // Requests that arrive while a byte is still on its way are refused.
      send_item(ACT_CMD, 8'h5A, 8'h00, 8'h00);
      send_item(ACT_DATA, 8'h3C, 8'h00, 8'h00);
      send_item(ACT_GOTO, 8'h00, 8'd3, 8'd0);
      send_item(ACT_INIT, 8'h00, 8'h00, 8'h00);
      send_item(ACT_CLEAR, 8'h00, 8'h00, 8'h00);
      run_until_idle();

      random_items(100);

      // Result side idles rarely, request side often.
      send_idle_pct = 62;
      rcv_stall_pct = 7;
      write_regs(0, 0, 0);
      random_items(50);
      write_regs(3, 7, 20);
      random_items(60);

      // No idling on either side.
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      write_regs(2, 30, 300);
      random_items(50);

      // Longest pulse, settle and init waits; the run ends while they are still counting.
      write_regs(20'(16'hFFFF), SETTLE_MAX, SETTLE_MAX);
      repeat (60) send_random_item();

      wait_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // Run limit.
   initial begin
      for (cycle_count = 0; cycle_count < RUN_LIMIT; cycle_count++) begin
         @(posedge clock);
      end
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
